FILE: rtl/scpd_pkg.sv
// shared types and constants for the sprite column post decoder
`default_nettype none

package scpd_pkg;

	// table geometry
	localparam int ENTRIES      = 256;
	localparam int LIGHT_LEVELS = 34;
	localparam int PALETTES     = 14;
	localparam int CMAP_DEPTH   = LIGHT_LEVELS * ENTRIES;
	localparam int PAL_DEPTH    = PALETTES * ENTRIES;
	localparam int LIGHT_W      = $clog2(LIGHT_LEVELS);
	localparam int PAL_W        = $clog2(PALETTES);

	// input kind codes
	localparam logic [1:0] KIND_CMAP_LOAD = 2'd0;
	localparam logic [1:0] KIND_PAL_LOAD  = 2'd1;
	localparam logic [1:0] KIND_COLUMN    = 2'd2;

	// top-row byte that ends a column
	localparam logic [7:0] END_MARK = 8'hFF;

	// configuration register indexes
	localparam logic [1:0] CFG_LIGHT_LEVEL    = 2'd0;
	localparam logic [1:0] CFG_PALETTE_SELECT = 2'd1;
	localparam logic [1:0] CFG_SPRITE_HEIGHT  = 2'd2;
	localparam logic [1:0] CFG_SPRITE_WIDTH   = 2'd3;

	// operation carried down the pipeline
	typedef enum logic [1:0] {
		OP_CMAP_LOAD,
		OP_PAL_LOAD,
		OP_PIXEL,
		OP_END
	} op_code_t;

	typedef struct packed {
		op_code_t    code;
		logic [9:0]  x;
		logic [9:0]  y;
		logic [7:0]  pix;
		logic [5:0]  trow;
		logic [7:0]  tidx;
		logic [31:0] tval;
	} op_t;

	typedef struct packed {
		logic [5:0] light_level;
		logic [3:0] palette_select;
		logic [9:0] sprite_height;
		logic [9:0] sprite_width;
	} cfg_t;

endpackage

`default_nettype wire

FILE: rtl/scpd_parser.sv
// post stream parser and first pipeline register
`default_nettype none

module scpd_parser (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire scpd_pkg::cfg_t  cfg,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [1:0]      kind,
	input  wire logic [7:0]      column_byte,
	input  wire logic [9:0]      column_x,
	input  wire logic            first_of_column,
	input  wire logic [5:0]      table_row,
	input  wire logic [7:0]      table_index,
	input  wire logic [31:0]     table_value,
	input  wire logic            s1_ready,
	output logic                 v_s1,
	output scpd_pkg::op_t        op_s1
);
	import scpd_pkg::*;

	typedef enum logic [5:0] {
		PH_TOP      = 6'b000001,
		PH_LEN      = 6'b000010,
		PH_PAD_PRE  = 6'b000100,
		PH_PIX      = 6'b001000,
		PH_PAD_POST = 6'b010000,
		PH_DONE     = 6'b100000
	} phase_t;

	phase_t     phase_q, phase_cur, phase_d;
	logic [9:0] row_q, row_d;
	logic [7:0] left_q, left_d, left_dec;
	logic       accept;
	logic       op_vld;
	op_t        op;

	// stage one empties or moves on
	assign in_ready = !v_s1 || s1_ready;
	assign accept   = in_valid && in_ready;
	assign left_dec = left_q - 8'd1;

	// decode the item and step the post grammar
	always_comb begin
		phase_cur = first_of_column ? PH_TOP : phase_q;
		phase_d   = phase_q;
		row_d     = row_q;
		left_d    = left_q;
		op_vld    = 1'b0;
		op.code   = OP_PIXEL;
		op.x      = column_x;
		op.y      = row_q;
		op.pix    = column_byte;
		op.trow   = table_row;
		op.tidx   = table_index;
		op.tval   = table_value;
		if (kind == KIND_CMAP_LOAD) begin
			op.code = OP_CMAP_LOAD;
			op_vld  = (int'(table_row) < LIGHT_LEVELS);
		end else if (kind == KIND_PAL_LOAD) begin
			op.code = OP_PAL_LOAD;
			op_vld  = (int'(table_row) < PALETTES);
		end else if (kind == KIND_COLUMN && column_x < cfg.sprite_width) begin
			phase_d = phase_cur;
			unique case (phase_cur)
				PH_TOP: begin
					if (column_byte == END_MARK) begin
						phase_d = PH_DONE;
						op.code = OP_END;
						op.y    = '0;
						op_vld  = 1'b1;
					end else begin
						row_d   = {2'b00, column_byte};
						phase_d = PH_LEN;
					end
				end
				PH_LEN: begin
					left_d  = column_byte;
					phase_d = PH_PAD_PRE;
				end
				PH_PAD_PRE: begin
					phase_d = (left_q == 8'd0) ? PH_PAD_POST : PH_PIX;
				end
				PH_PIX: begin
					op_vld = (row_q < cfg.sprite_height);
					row_d  = row_q + 10'd1;
					left_d = left_dec;
					if (left_dec == 8'd0) begin
						phase_d = PH_PAD_POST;
					end
				end
				PH_PAD_POST: begin
					phase_d = PH_TOP;
				end
				PH_DONE: begin
					phase_d = PH_DONE;
				end
				default: begin
					phase_d = PH_TOP;
				end
			endcase
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TOP;
			row_q   <= '0;
			left_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			row_q   <= row_d;
			left_q  <= left_d;
		end
	end

	// stage one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= accept && op_vld;
		end
	end

	// stage one payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/scpd_color_lut.sv
// colormap and palette memories with the two lookup stages and result register
`default_nettype none

module scpd_color_lut (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire scpd_pkg::cfg_t  cfg,
	input  wire logic            v_s1,
	input  wire scpd_pkg::op_t   op_s1,
	output logic                 s1_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [9:0]           pixel_x,
	output logic [9:0]           pixel_y,
	output logic [31:0]          pixel_color,
	output logic                 column_end
);
	import scpd_pkg::*;

	logic [7:0]  cmap_mem [0:CMAP_DEPTH-1];
	logic [31:0] pal_mem  [0:PAL_DEPTH-1];

	logic               en2, en3;
	logic               v_s2, v_s3;
	op_t                op_s2;
	logic [7:0]         cmi_s2;
	logic [31:0]        color_s3;
	logic [9:0]         x_s3, y_s3;
	logic               end_s3;
	logic [LIGHT_W-1:0] lsel;
	logic [PAL_W-1:0]   psel;

	// a stage loads when it is empty or its contents move on
	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign s1_ready = en2;

	// out of range selectors pick the last row
	assign lsel = (int'(cfg.light_level) >= LIGHT_LEVELS) ?
		LIGHT_W'(LIGHT_LEVELS - 1) : cfg.light_level[LIGHT_W-1:0];
	assign psel = (int'(cfg.palette_select) >= PALETTES) ?
		PAL_W'(PALETTES - 1) : cfg.palette_select[PAL_W-1:0];

	// colormap: load and lookup share stage two
	always_ff @(posedge clk) begin
		if (en2 && v_s1 && op_s1.code == OP_CMAP_LOAD) begin
			cmap_mem[{op_s1.trow[LIGHT_W-1:0], op_s1.tidx}] <= op_s1.tval[7:0];
		end
		if (en2) begin
			cmi_s2 <= cmap_mem[{lsel, op_s1.pix}];
			op_s2  <= op_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1 && op_s1.code != OP_CMAP_LOAD;
		end
	end

	// palette: load and lookup share stage three
	always_ff @(posedge clk) begin
		if (en3 && v_s2 && op_s2.code == OP_PAL_LOAD) begin
			pal_mem[{op_s2.trow[PAL_W-1:0], op_s2.tidx}] <= op_s2.tval;
		end
		if (en3) begin
			color_s3 <= pal_mem[{psel, cmi_s2}];
			x_s3     <= op_s2.x;
			y_s3     <= op_s2.y;
			end_s3   <= op_s2.code == OP_END;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2 && op_s2.code != OP_PAL_LOAD;
		end
	end

	// result port
	assign out_valid   = v_s3;
	assign pixel_x     = x_s3;
	assign pixel_y     = y_s3;
	assign column_end  = end_s3;
	assign pixel_color = end_s3 ? 32'd0 : color_s3;

endmodule

`default_nettype wire

FILE: rtl/sprite_column_post_decoder_unit.sv
// Sprite column post decoder top level. Takes one input item per cycle, while
// in_ready is high, on the in_valid/in_ready channel: colormap loads, palette
// loads and column stream bytes. Column bytes are parsed as posts (top row,
// length, pad, pixels, pad) until a top-row byte of 255, which yields an
// end-of-column result; each pixel byte is mapped through the selected colormap
// row and palette to a 32-bit color. The datapath is a three-stage pipeline
// (parse register, colormap read, palette read into the result register), and
// throughput is one item per cycle when out_ready does not stall it; each
// table memory takes one write and one read per cycle, so loads and lookups
// never compete for a port. Backpressure on out_ready stalls only the stages
// that are full. Table memories come up undefined and need no clearing pass;
// configuration writes on cfg_valid/cfg_index/cfg_data are always accepted.
`default_nettype none

module sprite_column_post_decoder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [9:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  column_byte,
	input  wire logic [9:0]  column_x,
	input  wire logic        first_of_column,
	input  wire logic [5:0]  table_row,
	input  wire logic [7:0]  table_index,
	input  wire logic [31:0] table_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [9:0]       pixel_x,
	output logic [9:0]       pixel_y,
	output logic [31:0]      pixel_color,
	output logic             column_end
);
	import scpd_pkg::*;

	cfg_t cfg_q;
	logic v_s1;
	logic s1_ready;
	op_t  op_s1;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.light_level    <= '0;
			cfg_q.palette_select <= '0;
			cfg_q.sprite_height  <= 10'd1;
			cfg_q.sprite_width   <= 10'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_LIGHT_LEVEL:    cfg_q.light_level    <= cfg_data[5:0];
				CFG_PALETTE_SELECT: cfg_q.palette_select <= cfg_data[3:0];
				CFG_SPRITE_HEIGHT:  cfg_q.sprite_height  <= cfg_data;
				CFG_SPRITE_WIDTH:   cfg_q.sprite_width   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// parse stage
	scpd_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (kind),
		.column_byte     (column_byte),
		.column_x        (column_x),
		.first_of_column (first_of_column),
		.table_row       (table_row),
		.table_index     (table_index),
		.table_value     (table_value),
		.s1_ready        (s1_ready),
		.v_s1            (v_s1),
		.op_s1           (op_s1)
	);

	// lookup stages
	scpd_color_lut u_lut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.v_s1        (v_s1),
		.op_s1       (op_s1),
		.s1_ready    (s1_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.column_end  (column_end)
	);

	// end-of-column transactions carry no pixel
	a_end_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && column_end |-> pixel_y == 10'd0 && pixel_color == 32'd0)
		else $error("end-of-column result carries pixel data");

	// pixels below the sprite height only
	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !column_end |-> pixel_y < cfg_q.sprite_height)
		else $error("pixel row at or past sprite height");

	// columns inside the sprite width only
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pixel_x < cfg_q.sprite_width)
		else $error("result column at or past sprite width");

	// input stalls only when the parse register is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && out_valid && !out_ready)
		else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire
